// ===== sv/wfs_pkg.sv =====
// wfs_pkg: shared types, register indexes and reset values for the
// timed wall-follow sequencer; used by every module of the block
package wfs_pkg;

  localparam int NowW   = 32;
  localparam int DistW  = 16;
  localparam int SpeedW = 8;
  localparam int TimeW  = 16;
  localparam int DriveW = 9;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;
  localparam int InDataW  = 64;
  localparam int OutDataW = 24;

  // fixed turn marks in ms
  localparam logic [NowW-1:0] TurnSpinMs  = 32'd200;
  localparam logic [NowW-1:0] TurnDriveMs = 32'd500;
  localparam logic [NowW-1:0] TurnEndMs   = 32'd700;

  // register reset values
  localparam logic [SpeedW-1:0] CruiseSpeedRst   = 8'd30;
  localparam logic [TimeW-1:0]  ForwardTimeRst   = 16'd800;
  localparam logic [TimeW-1:0]  ReverseTimeRst   = 16'd300;
  localparam logic [TimeW-1:0]  CheckTimeRst     = 16'd500;
  localparam logic [DistW-1:0]  ObstacleNearRst  = 16'd10;
  localparam logic [DistW-1:0]  ObstacleFarRst   = 16'd80;
  localparam logic [DistW-1:0]  WallTargetRst    = 16'd120;
  localparam logic [DistW-1:0]  WallBandRst      = 16'd10;

  typedef enum logic [CfgAddrW-1:0] {
    REG_CRUISE_SPEED  = 3'd0,
    REG_FORWARD_TIME  = 3'd1,
    REG_REVERSE_TIME  = 3'd2,
    REG_CHECK_TIME    = 3'd3,
    REG_OBSTACLE_NEAR = 3'd4,
    REG_OBSTACLE_FAR  = 3'd5,
    REG_WALL_TARGET   = 3'd6,
    REG_WALL_BAND     = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_FORWARD = 3'd0,
    PH_REVERSE = 3'd1,
    PH_LEFT    = 3'd2,
    PH_RIGHT   = 3'd3,
    PH_CHECK   = 3'd4
  } phase_t;

  typedef struct packed {
    logic [SpeedW-1:0] cruise_speed;
    logic [TimeW-1:0]  forward_time_ms;
    logic [TimeW-1:0]  reverse_time_ms;
    logic [TimeW-1:0]  check_time_ms;
    logic [DistW-1:0]  obstacle_near;
    logic [DistW-1:0]  obstacle_far;
    logic [DistW-1:0]  wall_target;
    logic [DistW-1:0]  wall_band;
  } cfg_t;

  typedef struct packed {
    logic                     emit;
    logic signed [DriveW-1:0] left_drive;
    logic signed [DriveW-1:0] right_drive;
    phase_t                   phase_nxt;
    logic [NowW-1:0]          start_nxt;
  } step_t;

endpackage

// ===== sv/timed_wall_follow_sequencer.sv =====
// timed_wall_follow_sequencer: result registered in the cycle after acceptance;
// one request per cycle unless out_tready stalls, the phase decision is a single
// pass of wfs_step; a turn past its 700 ms mark yields no result; out stage is a
// single register; rst_n (synchronous, low) restores the register defaults, forward
// phase, start 0; depends on wfs_pkg, wfs_cfg_regs, wfs_step
module timed_wall_follow_sequencer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [wfs_pkg::CfgAddrW-1:0]      cfg_addr,
  input  logic [wfs_pkg::CfgDataW-1:0]      cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // now_ms[31:0], front_distance[47:32], side_distance[63:48]
  input  logic [wfs_pkg::InDataW-1:0]       in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // left_drive[8:0], right_drive[17:9], zero fill [23:18]
  output logic [wfs_pkg::OutDataW-1:0]      out_tdata
);
  import wfs_pkg::*;

  cfg_t                     cfg;
  step_t                    step;
  phase_t                   phase_r, phase_nxt;
  logic [NowW-1:0]          start_r, start_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DriveW-1:0] left_r, right_r;
  logic                     accept;

  wfs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  wfs_step u_step (
    .cfg            (cfg),
    .phase          (phase_r),
    .phase_start_ms (start_r),
    .now_ms         (in_tdata[NowW-1:0]),
    .front_distance (in_tdata[NowW+DistW-1:NowW]),
    .side_distance  (in_tdata[NowW+2*DistW-1:NowW+DistW]),
    .step           (step)
  );

  // take a request whenever the result register is free or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    phase_nxt     = phase_r;
    start_nxt     = start_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (accept) begin
      phase_nxt     = step.phase_nxt;
      start_nxt     = step.start_nxt;
      out_valid_nxt = step.emit;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FORWARD;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept && step.emit) begin
      left_r  <= step.left_drive;
      right_r <= step.right_drive;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW-2*DriveW){1'b0}}, right_r, left_r};

  // forward phase always drives both motors at plus cruise speed
  a_forward_drive: assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == PH_FORWARD |=>
      out_tvalid && left_r == $signed({1'b0, cfg.cruise_speed}) && right_r == left_r)
    else $error("forward request did not yield a forward drive result");

  // check phase always stops both motors
  a_check_stop: assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == PH_CHECK |=> out_tvalid && left_r == '0 && right_r == '0)
    else $error("check request did not yield a stop result");

  // a phase change restarts the timer at the request time
  a_phase_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (phase_r == $past(phase_r)) || (start_r == $past(in_tdata[NowW-1:0])))
    else $error("phase changed without restarting the phase timer");

endmodule

// ===== sv/wfs_cfg_regs.sv =====
// wfs_cfg_regs: configuration register file written through a plain write port
// depends on wfs_pkg
module wfs_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [wfs_pkg::CfgAddrW-1:0]   cfg_addr,
  input  logic [wfs_pkg::CfgDataW-1:0]   cfg_wdata,
  output wfs_pkg::cfg_t                  cfg
);
  import wfs_pkg::*;

  cfg_t cfg_r;

  // register writes, reset to the power-up settings
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cruise_speed    <= CruiseSpeedRst;
      cfg_r.forward_time_ms <= ForwardTimeRst;
      cfg_r.reverse_time_ms <= ReverseTimeRst;
      cfg_r.check_time_ms   <= CheckTimeRst;
      cfg_r.obstacle_near   <= ObstacleNearRst;
      cfg_r.obstacle_far    <= ObstacleFarRst;
      cfg_r.wall_target     <= WallTargetRst;
      cfg_r.wall_band       <= WallBandRst;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_CRUISE_SPEED:  cfg_r.cruise_speed    <= cfg_wdata[SpeedW-1:0];
        REG_FORWARD_TIME:  cfg_r.forward_time_ms <= cfg_wdata;
        REG_REVERSE_TIME:  cfg_r.reverse_time_ms <= cfg_wdata;
        REG_CHECK_TIME:    cfg_r.check_time_ms   <= cfg_wdata;
        REG_OBSTACLE_NEAR: cfg_r.obstacle_near   <= cfg_wdata;
        REG_OBSTACLE_FAR:  cfg_r.obstacle_far    <= cfg_wdata;
        REG_WALL_TARGET:   cfg_r.wall_target     <= cfg_wdata;
        REG_WALL_BAND:     cfg_r.wall_band       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/wfs_step.sv =====
// wfs_step: combinational phase decision and drive command for one request
// depends on wfs_pkg
module wfs_step (
  input  wfs_pkg::cfg_t                  cfg,
  input  wfs_pkg::phase_t                phase,
  input  logic [wfs_pkg::NowW-1:0]       phase_start_ms,
  input  logic [wfs_pkg::NowW-1:0]       now_ms,
  input  logic [wfs_pkg::DistW-1:0]      front_distance,
  input  logic [wfs_pkg::DistW-1:0]      side_distance,
  output wfs_pkg::step_t                 step
);
  import wfs_pkg::*;

  logic [NowW-1:0]          dt;
  logic signed [DriveW-1:0] pos;
  logic signed [DriveW-1:0] neg;
  logic [DistW:0]           hi;
  logic signed [DistW+1:0]  lo;
  logic signed [DistW+1:0]  side_s;
  logic                     obstacle;
  logic                     due;

  // elapsed time wraps at 32 bits
  assign dt  = now_ms - phase_start_ms;
  assign pos = $signed({1'b0, cfg.cruise_speed});
  assign neg = -pos;

  // wall band limits; low limit may go negative
  assign hi     = {1'b0, cfg.wall_target} + {1'b0, cfg.wall_band};
  assign lo     = $signed({2'b00, cfg.wall_target}) - $signed({2'b00, cfg.wall_band});
  assign side_s = $signed({2'b00, side_distance});
  assign obstacle = (front_distance >= cfg.obstacle_near) &&
                    (front_distance <= cfg.obstacle_far);
  assign due = dt >= {{(NowW-TimeW){1'b0}}, cfg.check_time_ms};

  // per-phase drive and next state
  always_comb begin
    step.emit        = 1'b1;
    step.left_drive  = '0;
    step.right_drive = '0;
    step.phase_nxt   = phase;
    step.start_nxt   = phase_start_ms;
    unique case (phase)
      PH_FORWARD: begin
        step.left_drive  = pos;
        step.right_drive = pos;
        if (dt >= {{(NowW-TimeW){1'b0}}, cfg.forward_time_ms}) begin
          step.phase_nxt = PH_CHECK;
          step.start_nxt = now_ms;
        end
      end
      PH_REVERSE: begin
        step.left_drive  = neg;
        step.right_drive = neg;
        if (dt >= {{(NowW-TimeW){1'b0}}, cfg.reverse_time_ms}) begin
          step.phase_nxt = PH_CHECK;
          step.start_nxt = now_ms;
        end
      end
      PH_LEFT, PH_RIGHT: begin
        priority if (dt < TurnSpinMs) begin
          step.left_drive  = (phase == PH_LEFT) ? neg : pos;
          step.right_drive = (phase == PH_LEFT) ? pos : neg;
        end else if (dt < TurnDriveMs) begin
          step.left_drive  = pos;
          step.right_drive = pos;
        end else if (dt < TurnEndMs) begin
          step.left_drive  = (phase == PH_LEFT) ? pos : neg;
          step.right_drive = (phase == PH_LEFT) ? neg : pos;
        end else begin
          step.emit      = 1'b0;
          step.phase_nxt = PH_CHECK;
          step.start_nxt = now_ms;
        end
      end
      PH_CHECK: begin
        if (due) begin
          step.start_nxt = now_ms;
          // with no obstacle, side exactly at the low limit keeps check
          priority if (obstacle)                      step.phase_nxt = PH_REVERSE;
          else if ({1'b0, side_distance} > hi)        step.phase_nxt = PH_RIGHT;
          else if (side_s > lo)                       step.phase_nxt = PH_FORWARD;
          else if (side_s < lo)                       step.phase_nxt = PH_LEFT;
          else                                        step.phase_nxt = PH_CHECK;
        end
      end
      default: ;
    endcase
  end

endmodule
